// ===== design/trs_pkg.sv =====
// Shared types and constants for the trail ribbon strip builder.
package trs_pkg;

  localparam int MAX_BATCH_VERTICES_DEF = 256;
  localparam int MAX_SEGMENTS_DEF       = 127;
  localparam int QUEUE_DEPTH            = 4;

  localparam int IN_DATA_W  = 256;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 144;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NOW_TIME   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_LIFE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd2;

  localparam logic [31:0] NOW_TIME_RST   = 32'd0;
  localparam logic [15:0] INV_LIFE_RST   = 16'd6554;
  localparam logic [15:0] HALF_WIDTH_RST = 16'd8192;

  localparam logic [16:0] AGE_ONE = 17'h10000;

  // What the back end does with a queued item
  typedef enum logic [1:0] {
    KIND_EOF,
    KIND_FIRST,
    KIND_MID,
    KIND_LAST
  } kind_t;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic [31:0] now_time;
    logic [15:0] inverse_life;
    logic [15:0] half_width;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    vec3_t       vp;
    vec3_t       vm;
    logic [6:0]  tex_u;
    logic [16:0] age;
    logic [15:0] strength;
    logic        bs;
  } entry_t;

endpackage

// ===== design/trs_front.sv =====
// Front end: accepts items, tracks batch state and computes edge vertices and age.
module trs_front #(
  parameter int MAX_BATCH_VERTICES = trs_pkg::MAX_BATCH_VERTICES_DEF,
  parameter int MAX_SEGMENTS       = trs_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [trs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [trs_pkg::IN_USER_W-1:0]  in_tuser,
  input  trs_pkg::cfg_t                  cfg,
  input  logic                           q_full,
  output logic                           q_push,
  output trs_pkg::entry_t                q_entry
);
  import trs_pkg::*;

  localparam int CNT_W = $clog2(MAX_BATCH_VERTICES + 1);
  localparam int SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 2;
  localparam logic [SUM_W-1:0] MAX_V = SUM_W'(MAX_BATCH_VERTICES);

  logic        action;
  vec3_t       in_pos, in_tan;
  logic [15:0] in_str;
  logic [31:0] in_laid;
  logic [6:0]  idx, cnt;
  logic        drop, is_first, is_last, reset_batch, item_bs;
  logic [SUM_W-1:0] need, base, sum;
  logic [CNT_W-1:0] bcount_r, bcount_nxt;
  logic             bpend_r, bpend_nxt;
  logic        acc, s1_free, s2_free;

  logic        s1_v_r;
  kind_t       s1_kind_r;
  vec3_t       s1_pos_r, s1_tan_r;
  logic [15:0] s1_str_r;
  logic [31:0] s1_laid_r;
  logic [6:0]  s1_idx_r;
  logic        s1_bs_r;

  logic        s2_v_r;
  kind_t       s2_kind_r;
  vec3_t       s2_pos_r;
  logic signed [48:0] s2_prod_r [3];
  logic [47:0] s2_age_prod_r;
  logic        s2_future_r;
  logic [15:0] s2_str_r;
  logic [6:0]  s2_idx_r;
  logic        s2_bs_r;

  assign action  = in_tuser[0];
  assign in_pos  = in_tdata[95:0];
  assign in_tan  = in_tdata[191:96];
  assign in_str  = in_tdata[207:192];
  assign in_laid = in_tdata[239:208];
  assign idx     = in_tdata[246:240];
  assign cnt     = in_tdata[253:247];

  assign drop     = (cnt < 7'd2) || (idx >= cnt) || (32'(cnt) > 32'(MAX_SEGMENTS));
  assign is_first = (idx == 7'd0);
  assign is_last  = (idx == cnt - 7'd1);

  // Open a fresh batch when the whole emitter would overflow the current one
  assign need        = SUM_W'({cnt, 1'b0}) + SUM_W'(2) + SUM_W'(bcount_r);
  assign reset_batch = is_first && (need > MAX_V);
  assign base        = reset_batch ? '0 : SUM_W'(bcount_r);
  assign sum         = base + ((is_first || is_last) ? SUM_W'(3) : SUM_W'(2));
  assign item_bs     = reset_batch || bpend_r;

  assign s2_free   = !s2_v_r || !q_full;
  assign s1_free   = !s1_v_r || s2_free;
  assign in_tready = s1_free;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    bcount_nxt = bcount_r;
    bpend_nxt  = bpend_r;
    if (acc) begin
      if (action) begin
        bcount_nxt = '0;
        bpend_nxt  = 1'b1;
      end else if (!drop) begin
        bcount_nxt = (sum > MAX_V) ? MAX_V[CNT_W-1:0] : sum[CNT_W-1:0];
        bpend_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= '0;
      bpend_r  <= 1'b1;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      bcount_r <= bcount_nxt;
      bpend_r  <= bpend_nxt;
      if (s1_free) s1_v_r <= acc && (action || !drop);
      if (s2_free) s2_v_r <= s1_v_r;
    end
  end

  // Stage 1: hold the accepted item
  always_ff @(posedge clk) begin
    if (acc) begin
      if (action)        s1_kind_r <= KIND_EOF;
      else if (is_first) s1_kind_r <= KIND_FIRST;
      else if (is_last)  s1_kind_r <= KIND_LAST;
      else               s1_kind_r <= KIND_MID;
      s1_pos_r  <= in_pos;
      s1_tan_r  <= in_tan;
      s1_str_r  <= in_str;
      s1_laid_r <= in_laid;
      s1_idx_r  <= idx;
      s1_bs_r   <= item_bs;
    end
  end

  // Stage 2: one multiplier per lane plus one for age
  always_ff @(posedge clk) begin
    if (s2_free) begin
      for (int k = 0; k < 3; k++) begin
        s2_prod_r[k] <= $signed(s1_tan_r[k]) * $signed({1'b0, cfg.half_width});
      end
      s2_age_prod_r <= (cfg.now_time - s1_laid_r) * cfg.inverse_life;
      s2_future_r   <= (s1_laid_r > cfg.now_time);
      s2_kind_r     <= s1_kind_r;
      s2_pos_r      <= s1_pos_r;
      s2_str_r      <= s1_str_r;
      s2_idx_r      <= s1_idx_r;
      s2_bs_r       <= s1_bs_r;
    end
  end

  // Floor shift of the product gives the offset; the minus edge floors the negated product
  always_comb begin
    logic signed [48:0] neg;
    q_entry = '0;
    for (int k = 0; k < 3; k++) begin
      neg = -s2_prod_r[k];
      q_entry.vp[k] = s2_pos_r[k] + s2_prod_r[k][47:16];
      q_entry.vm[k] = s2_pos_r[k] + neg[47:16];
    end
    q_entry.kind     = s2_kind_r;
    q_entry.tex_u    = s2_idx_r;
    q_entry.strength = s2_str_r;
    q_entry.bs       = s2_bs_r;
    if (s2_future_r)                             q_entry.age = '0;
    else if (s2_age_prod_r[47:16] > 32'(AGE_ONE)) q_entry.age = AGE_ONE;
    else                                         q_entry.age = s2_age_prod_r[32:16];
  end

  assign q_push = s2_v_r && !q_full;

endmodule

// ===== design/trs_queue.sv =====
// Short queue of computed items between the front end and the back end.
module trs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  trs_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output trs_pkg::entry_t rd_entry,
  output logic            empty
);
  import trs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  entry_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [CW-1:0]      cnt_r;

  assign full     = (cnt_r == DEPTH_C);
  assign empty    = (cnt_r == '0);
  assign rd_entry = slots_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wp_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      if (pop)  rp_r <= (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== design/trs_back.sv =====
// Back end: expands each queued item into its vertices (or a draw-end marker) on the output register.
module trs_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  trs_pkg::entry_t                 q_entry,
  input  logic                            q_empty,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [trs_pkg::OUT_DATA_W-1:0]  out_tdata,  // vert_x, vert_y, vert_z, tex_u, tex_v, age, vert_strength
  output logic [trs_pkg::OUT_USER_W-1:0]  out_tuser,  // batch_start, draw_end
  output logic                            out_tlast
);
  import trs_pkg::*;

  logic [1:0] k_r;
  logic       load, res_last, use_minus, is_eof;
  logic       out_v_r;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic [OUT_USER_W-1:0] user_r, user_nxt;
  logic                  last_r;
  vec3_t      vsel;

  always_comb begin
    case (q_entry.kind)
      KIND_FIRST: begin
        res_last  = (k_r == 2'd2);
        use_minus = (k_r == 2'd2);
      end
      KIND_MID: begin
        res_last  = (k_r == 2'd1);
        use_minus = (k_r == 2'd1);
      end
      KIND_LAST: begin
        res_last  = (k_r == 2'd2);
        use_minus = (k_r != 2'd0);
      end
      default: begin
        res_last  = 1'b1;
        use_minus = 1'b0;
      end
    endcase
  end

  assign is_eof = (q_entry.kind == KIND_EOF);
  assign vsel   = use_minus ? q_entry.vm : q_entry.vp;

  always_comb begin
    data_nxt = '0;
    user_nxt = '0;
    if (is_eof) begin
      user_nxt[1] = 1'b1;
    end else begin
      data_nxt[95:0]    = vsel;
      data_nxt[102:96]  = q_entry.tex_u;
      data_nxt[103]     = use_minus;
      data_nxt[120:104] = q_entry.age;
      data_nxt[136:121] = q_entry.strength;
      user_nxt[0]       = (k_r == 2'd0) && q_entry.bs;
    end
  end

  assign load  = !q_empty && (!out_v_r || out_tready);
  assign q_pop = load && res_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (load) k_r <= res_last ? 2'd0 : k_r + 2'd1;
      if (load)            out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
      last_r <= res_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// ===== design/trail_ribbon_strip_builder.sv =====
// Top level of the trail ribbon strip builder: registers, front end, queue, back end.
//
//   channel  | direction | carries
//   ---------+-----------+---------------------------------------------
//   in_      | in        | one trail segment or end-of-frame per item
//   out_     | out       | one strip vertex or draw-end marker per item
//   cfg_     | in        | register write, no read-back
//
// The front end takes an item every cycle until its two-stage multiply pipe and the
// four-entry queue fill; the back end sends one vertex per cycle while out_tready is high,
// so a segment yields 2 or 3 vertices and an end-of-frame one marker. The first vertex
// of an item passes through stage 1, stage 2, the queue and the output register.
// Reset is synchronous; it empties the pipe and queue and opens a new batch.
// A stalled output holds its item and backs the queue, then the input, up.
module trail_ribbon_strip_builder #(
  parameter int MAX_BATCH_VERTICES = trs_pkg::MAX_BATCH_VERTICES_DEF,
  parameter int MAX_SEGMENTS       = trs_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pos_x, pos_y, pos_z, tan_x, tan_y, tan_z, strength, time_laid, seg_index, seg_count
  input  logic [trs_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [trs_pkg::IN_USER_W-1:0]   in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // vert_x, vert_y, vert_z, tex_u, tex_v, age, vert_strength
  output logic [trs_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [trs_pkg::OUT_USER_W-1:0]  out_tuser,  // batch_start, draw_end
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [trs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import trs_pkg::*;

  cfg_t   cfg_r;
  logic   q_push, q_full, q_pop, q_empty;
  entry_t wr_entry, rd_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.now_time     <= NOW_TIME_RST;
      cfg_r.inverse_life <= INV_LIFE_RST;
      cfg_r.half_width   <= HALF_WIDTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NOW_TIME:   cfg_r.now_time     <= cfg_wdata;
        CFG_INV_LIFE:   cfg_r.inverse_life <= cfg_wdata[15:0];
        CFG_HALF_WIDTH: cfg_r.half_width   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  trs_front #(
    .MAX_BATCH_VERTICES(MAX_BATCH_VERTICES),
    .MAX_SEGMENTS      (MAX_SEGMENTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (wr_entry)
  );

  trs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_entry(wr_entry),
    .full    (q_full),
    .pop     (q_pop),
    .rd_entry(rd_entry),
    .empty   (q_empty)
  );

  trs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_entry   (rd_entry),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
